### src/lpcc_pkg.sv
package lpcc_pkg;

  // Field widths of one item on each channel.
  localparam int unsigned PageW    = 16;
  localparam int unsigned SpW      = 11;
  localparam int unsigned KindW    = 2;
  localparam int unsigned SlotIdxW = 5;

  // Default number of cache slots.
  localparam int unsigned DefaultSlots = 32;

  // A sector is 512 bytes of 16-byte pages; the stack pointer counts words.
  localparam int unsigned SectorShift = 5;
  localparam int unsigned SpShift     = 3;

  localparam logic [PageW-1:0] EmptyTag = '1;

  // Result kinds.
  localparam logic [KindW-1:0] KindWriteBack = 2'd0;
  localparam logic [KindW-1:0] KindHit       = 2'd1;
  localparam logic [KindW-1:0] KindFill      = 2'd2;
  localparam logic [KindW-1:0] KindBypass    = 2'd3;

  // Command broadcast from the controller to every cell of the ring.
  typedef struct packed {
    logic rotate;     // every cell takes its neighbor's contents
    logic promote;    // move the keyed slot to the front of the recency order
    logic set_dirty;  // with promote: mark the keyed slot dirty
    logic fill;       // load the keyed slot with a new tag and mark it dirty
    logic wb_clear;   // with rotate: clear the dirty mark leaving the read point
  } lpcc_cmd_t;

endpackage

### src/lru_page_cache_controller_core.sv
// The block takes one item at a time: it stalls its input from accepting an item until
// the last result of that item is loaded into the output register. The ring of slot
// cells turns one cell per cycle for the search and, while no write-back waits for
// room in the output register, for the flush.
// Reset: every slot is empty and clean, recency order is slot 0 first, no result is held.
module lru_page_cache_controller_core #(
  parameter int unsigned SLOTS = lpcc_pkg::DefaultSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Access channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lpcc_pkg::PageW-1:0]    page_address_i,
  input  logic                          is_write_i,
  input  logic [lpcc_pkg::SpW-1:0]      stack_pointer_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lpcc_pkg::KindW-1:0]    result_kind_o,
  output logic [lpcc_pkg::SlotIdxW-1:0] slot_index_o,
  output logic [lpcc_pkg::PageW-1:0]    result_page_o,
  output logic                          last_o
);
  import lpcc_pkg::*;

  // The slot state lives in a ring of SLOTS cells. Each cell carries one
  // slot's number, its recency rank, its tag and its dirty mark. When the ring
  // turns, every cell passes its contents to the next one, and the last cell
  // is the single read point the controller looks at. A full turn of SLOTS
  // steps brings every slot back to its home cell, so the slots pass the
  // read point in descending slot order: exactly the order write-backs leave.
  //
  // One access runs as follows:
  //   SEARCH  one full turn. The matching slot of lowest rank (the first hit
  //           in recency order) and the slot of highest rank (the tail) are
  //           captured as they pass.
  //   DECIDE  a hit moves its slot to the front in one broadcast step and is
  //           reported; a read miss is reported as a bypass. A write miss
  //           whose tail is dirty and not below the stack limit goes on to
  //           FLUSH, any other write miss straight to FILL.
  //   FLUSH   a second full turn. Every dirty slot in the tail's sector is
  //           reported as it passes the read point and loses its dirty mark
  //           on the way back into the ring. The turn pauses while a result
  //           waits for room in the output register.
  //   FILL    the tail moves to the front, takes the new page, turns dirty,
  //           and the fill is reported as the last result of the access.

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam logic [SlotW-1:0] RankLast = SlotW'(SLOTS - 1);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StSearch = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StFlush  = 3'd3;
  localparam logic [2:0] StFill   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [SlotW-1:0] step_q, step_d;

  // The accepted access.
  logic [PageW-1:0] page_q, page_d;
  logic             wr_q, wr_d;
  logic [SpW-1:0]   sp_q, sp_d;

  // What the search turn found.
  logic             found_q, found_d;
  logic [SlotW-1:0] best_slot_q, best_slot_d;
  logic [SlotW-1:0] best_rank_q, best_rank_d;
  logic [SlotW-1:0] tail_slot_q, tail_slot_d;
  logic [PageW-1:0] tail_tag_q, tail_tag_d;
  logic             tail_dirty_q, tail_dirty_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [SlotIdxW-1:0] slot_idx_q, slot_idx_d;
  logic [PageW-1:0] res_page_q, res_page_d;
  logic             last_q, last_d;

  // Ring interface.
  lpcc_cmd_t        cmd;
  logic [SlotW-1:0] key_slot;
  logic [SlotW-1:0] key_rank;
  logic [SlotW-1:0] rp_slot;
  logic [SlotW-1:0] rp_rank;
  logic [PageW-1:0] rp_tag;
  logic             rp_dirty;

  logic can_load;
  logic in_accept;
  logic rp_match;
  logic rp_in_sector;
  logic need_flush;

  assign can_load     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != StIdle);
  assign in_accept    = in_valid_i && !in_stall_o;
  assign rp_match     = (rp_tag == page_q);
  assign rp_in_sector = rp_dirty &&
                        (rp_tag[PageW-1:SectorShift] == tail_tag_q[PageW-1:SectorShift]);
  assign need_flush   = tail_dirty_q && (tail_tag_q >= PageW'(sp_q >> SpShift));

  // Broadcast keys: the hit slot in DECIDE, the tail slot in FILL.
  assign key_slot = (state_q == StFill) ? tail_slot_q : best_slot_q;
  assign key_rank = (state_q == StFill) ? RankLast : best_rank_q;

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    page_d       = page_q;
    wr_d         = wr_q;
    sp_d         = sp_q;
    found_d      = found_q;
    best_slot_d  = best_slot_q;
    best_rank_d  = best_rank_q;
    tail_slot_d  = tail_slot_q;
    tail_tag_d   = tail_tag_q;
    tail_dirty_d = tail_dirty_q;

    out_valid_d  = out_valid_q && out_stall_i;
    kind_d       = kind_q;
    slot_idx_d   = slot_idx_q;
    res_page_d   = res_page_q;
    last_d       = last_q;

    cmd          = '0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          page_d  = page_address_i;
          wr_d    = is_write_i;
          sp_d    = stack_pointer_i;
          found_d = 1'b0;
          step_d  = '0;
          state_d = StSearch;
        end
      end

      StSearch: begin
        cmd.rotate = 1'b1;
        if (rp_match && (!found_q || (rp_rank < best_rank_q))) begin
          found_d     = 1'b1;
          best_slot_d = rp_slot;
          best_rank_d = rp_rank;
        end
        if (rp_rank == RankLast) begin
          tail_slot_d  = rp_slot;
          tail_tag_d   = rp_tag;
          tail_dirty_d = rp_dirty;
        end
        step_d = step_q + SlotW'(1);
        if (step_q == RankLast) begin
          state_d = StDecide;
        end
      end

      StDecide: begin
        priority if (found_q) begin
          if (can_load) begin
            cmd.promote   = 1'b1;
            cmd.set_dirty = wr_q;
            out_valid_d   = 1'b1;
            kind_d        = KindHit;
            slot_idx_d    = SlotIdxW'(best_slot_q);
            res_page_d    = page_q;
            last_d        = 1'b1;
            state_d       = StIdle;
          end
        end else if (!wr_q) begin
          if (can_load) begin
            out_valid_d = 1'b1;
            kind_d      = KindBypass;
            slot_idx_d  = '0;
            res_page_d  = page_q;
            last_d      = 1'b1;
            state_d     = StIdle;
          end
        end else if (need_flush) begin
          step_d  = '0;
          state_d = StFlush;
        end else begin
          state_d = StFill;
        end
      end

      StFlush: begin
        // A slot that must be written back waits at the read point until
        // the output register has room for it.
        if (!rp_in_sector || can_load) begin
          cmd.rotate   = 1'b1;
          cmd.wb_clear = rp_in_sector;
          if (rp_in_sector) begin
            out_valid_d = 1'b1;
            kind_d      = KindWriteBack;
            slot_idx_d  = SlotIdxW'(rp_slot);
            res_page_d  = rp_tag;
            last_d      = 1'b0;
          end
          step_d = step_q + SlotW'(1);
          if (step_q == RankLast) begin
            state_d = StFill;
          end
        end
      end

      StFill: begin
        if (can_load) begin
          cmd.promote = 1'b1;
          cmd.fill    = 1'b1;
          out_valid_d = 1'b1;
          kind_d      = KindFill;
          slot_idx_d  = SlotIdxW'(tail_slot_q);
          res_page_d  = page_q;
          last_d      = 1'b1;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    wr_q         <= wr_d;
    sp_q         <= sp_d;
    best_slot_q  <= best_slot_d;
    best_rank_q  <= best_rank_d;
    tail_slot_q  <= tail_slot_d;
    tail_tag_q   <= tail_tag_d;
    tail_dirty_q <= tail_dirty_d;
    kind_q       <= kind_d;
    slot_idx_q   <= slot_idx_d;
    res_page_q   <= res_page_d;
    last_q       <= last_d;
  end

  lpcc_chain #(.SLOTS(SLOTS)) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .key_slot_i(key_slot),
    .key_rank_i(key_rank),
    .fill_tag_i(page_q),
    .rp_slot_o (rp_slot),
    .rp_rank_o (rp_rank),
    .rp_tag_o  (rp_tag),
    .rp_dirty_o(rp_dirty)
  );

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign slot_index_o  = slot_idx_q;
  assign result_page_o = res_page_q;
  assign last_o        = last_q;

endmodule

### src/lpcc_cell.sv
module lpcc_cell #(
  parameter int unsigned SLOTS   = lpcc_pkg::DefaultSlots,
  parameter int unsigned CELL_ID = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpcc_pkg::lpcc_cmd_t           cmd_i,
  input  logic [$clog2(SLOTS)-1:0]      key_slot_i,
  input  logic [$clog2(SLOTS)-1:0]      key_rank_i,
  input  logic [lpcc_pkg::PageW-1:0]    fill_tag_i,
  input  logic [$clog2(SLOTS)-1:0]      prev_slot_i,
  input  logic [$clog2(SLOTS)-1:0]      prev_rank_i,
  input  logic [lpcc_pkg::PageW-1:0]    prev_tag_i,
  input  logic                          prev_dirty_i,
  output logic [$clog2(SLOTS)-1:0]      slot_o,
  output logic [$clog2(SLOTS)-1:0]      rank_o,
  output logic [lpcc_pkg::PageW-1:0]    tag_o,
  output logic                          dirty_o
);
  import lpcc_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);

  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] rank_q, rank_d;
  logic [PageW-1:0] tag_q, tag_d;
  logic             dirty_q, dirty_d;
  logic             is_key;

  assign is_key = (slot_q == key_slot_i);

  // Each cell holds one slot: its number, its place in the recency order
  // (0 is most recent), its tag and its dirty mark.
  always_comb begin
    slot_d  = slot_q;
    rank_d  = rank_q;
    tag_d   = tag_q;
    dirty_d = dirty_q;
    if (cmd_i.rotate) begin
      slot_d  = prev_slot_i;
      rank_d  = prev_rank_i;
      tag_d   = prev_tag_i;
      dirty_d = prev_dirty_i;
    end else begin
      if (cmd_i.promote) begin
        if (is_key) begin
          rank_d  = '0;
          dirty_d = dirty_q | cmd_i.set_dirty;
        end else if (rank_q < key_rank_i) begin
          rank_d = rank_q + SlotW'(1);
        end
      end
      if (cmd_i.fill && is_key) begin
        tag_d   = fill_tag_i;
        dirty_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= SlotW'(CELL_ID);
      rank_q  <= SlotW'(CELL_ID);
      tag_q   <= EmptyTag;
      dirty_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      rank_q  <= rank_d;
      tag_q   <= tag_d;
      dirty_q <= dirty_d;
    end
  end

  assign slot_o  = slot_q;
  assign rank_o  = rank_q;
  assign tag_o   = tag_q;
  assign dirty_o = dirty_q;

endmodule

### src/lpcc_chain.sv
module lpcc_chain #(
  parameter int unsigned SLOTS = lpcc_pkg::DefaultSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpcc_pkg::lpcc_cmd_t           cmd_i,
  input  logic [$clog2(SLOTS)-1:0]      key_slot_i,
  input  logic [$clog2(SLOTS)-1:0]      key_rank_i,
  input  logic [lpcc_pkg::PageW-1:0]    fill_tag_i,
  output logic [$clog2(SLOTS)-1:0]      rp_slot_o,
  output logic [$clog2(SLOTS)-1:0]      rp_rank_o,
  output logic [lpcc_pkg::PageW-1:0]    rp_tag_o,
  output logic                          rp_dirty_o
);
  import lpcc_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);

  logic [SlotW-1:0] slot_w  [SLOTS];
  logic [SlotW-1:0] rank_w  [SLOTS];
  logic [PageW-1:0] tag_w   [SLOTS];
  logic             dirty_w [SLOTS];

  // The last cell is the read point; its contents wrap around to the first
  // cell, with the dirty mark dropped when the slot was just written back.
  logic wrap_dirty;
  assign wrap_dirty = dirty_w[SLOTS-1] & ~cmd_i.wb_clear;

  for (genvar c = 0; c < SLOTS; c++) begin : g_cell
    if (c == 0) begin : g_first
      lpcc_cell #(.SLOTS(SLOTS), .CELL_ID(c)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd_i),
        .key_slot_i  (key_slot_i),
        .key_rank_i  (key_rank_i),
        .fill_tag_i  (fill_tag_i),
        .prev_slot_i (slot_w[SLOTS-1]),
        .prev_rank_i (rank_w[SLOTS-1]),
        .prev_tag_i  (tag_w[SLOTS-1]),
        .prev_dirty_i(wrap_dirty),
        .slot_o      (slot_w[c]),
        .rank_o      (rank_w[c]),
        .tag_o       (tag_w[c]),
        .dirty_o     (dirty_w[c])
      );
    end else begin : g_next
      lpcc_cell #(.SLOTS(SLOTS), .CELL_ID(c)) u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd_i),
        .key_slot_i  (key_slot_i),
        .key_rank_i  (key_rank_i),
        .fill_tag_i  (fill_tag_i),
        .prev_slot_i (slot_w[c-1]),
        .prev_rank_i (rank_w[c-1]),
        .prev_tag_i  (tag_w[c-1]),
        .prev_dirty_i(dirty_w[c-1]),
        .slot_o      (slot_w[c]),
        .rank_o      (rank_w[c]),
        .tag_o       (tag_w[c]),
        .dirty_o     (dirty_w[c])
      );
    end
  end

  assign rp_slot_o  = slot_w[SLOTS-1];
  assign rp_rank_o  = rank_w[SLOTS-1];
  assign rp_tag_o   = tag_w[SLOTS-1];
  assign rp_dirty_o = dirty_w[SLOTS-1];

endmodule

### verif/lru_page_cache_controller_core_test.sv
module lru_page_cache_controller_core_test;
  import lpcc_pkg::*;

  // The block under test is built with its default slot count, and the
  // predictor below mirrors that size.
  localparam int unsigned Slots = DefaultSlots;
  localparam logic [5:0] NoLink = 6'h3f;

  // A hung run is stopped here. The slowest legal run is far shorter, even with
  // every item producing up to 33 results, each behind a long random stall, and
  // one long output hold-off.
  localparam int unsigned CycleLimit = 2_000_000;

  // After the last expected result, stray results could still come out of a
  // flush scan, so the output side keeps watching for a little over its span.
  localparam int unsigned SettleCycles = 2 * Slots + 20;

  // Length of the output hold-off that fills the block and stalls its input.
  localparam int unsigned LongHold = 600;

  localparam int unsigned NumRows = 22;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [SlotIdxW-1:0] slot;
    logic [PageW-1:0]    page;
    logic                is_last;
  } cache_result_t;

  // One access, plus an expectation typed in by hand where the table has one.
  typedef struct packed {
    logic [PageW-1:0] page;
    logic             wr;
    logic [SpW-1:0]   sp;
    logic             fixed;
    cache_result_t    want;
  } access_t;

  // Every input of the block starts at a known value.
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                in_valid_i     = 1'b0;
  logic                in_stall_o;
  logic [PageW-1:0]    page_address_i = '0;
  logic                is_write_i     = 1'b0;
  logic [SpW-1:0]      stack_pointer_i = '0;
  logic                out_valid_o;
  logic                out_stall_i    = 1'b0;
  logic [KindW-1:0]    result_kind_o;
  logic [SlotIdxW-1:0] slot_index_o;
  logic [PageW-1:0]    result_page_o;
  logic                last_o;

  lru_page_cache_controller_core #(
    .SLOTS(Slots)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .page_address_i (page_address_i),
    .is_write_i     (is_write_i),
    .stack_pointer_i(stack_pointer_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .slot_index_o   (slot_index_o),
    .result_page_o  (result_page_o),
    .last_o         (last_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the cache state: recency list, tags and dirty marks.
  logic [5:0]       link_r  [Slots];
  logic             dirty_r [Slots];
  logic [PageW-1:0] tag_r   [Slots];
  int unsigned      head_r;

  cache_result_t lookup_results[$];   // results of the access just predicted
  cache_result_t pending_results[$];  // results the block still owes
  access_t       access_queue[$];     // items not yet offered
  access_t       directed_table[NumRows];

  access_t       offered;
  cache_result_t want;
  logic [PageW-1:0] pool_base = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;
  bit          hold_request  = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned accepted_count = 0;
  int unsigned kind_count[4] = '{default: 0};
  int          failures      = 0;

  function automatic cache_result_t result_of(logic [KindW-1:0] kind, int unsigned slot,
                                              logic [PageW-1:0] page, logic is_last);
    cache_result_t r;
    r.kind    = kind;
    r.slot    = SlotIdxW'(slot);
    r.page    = page;
    r.is_last = is_last;
    return r;
  endfunction

  // A table row that is checked against the predictor.
  function automatic access_t row(logic [PageW-1:0] page, logic wr, logic [SpW-1:0] sp);
    access_t a;
    a = '0;
    a.page = page;
    a.wr   = wr;
    a.sp   = sp;
    return a;
  endfunction

  // A table row whose single result is typed in.
  function automatic access_t fixed_row(logic [PageW-1:0] page, logic wr,
                                        logic [SpW-1:0] sp, logic [KindW-1:0] kind,
                                        int unsigned slot, logic [PageW-1:0] rpage);
    access_t a;
    a = row(page, wr, sp);
    a.fixed = 1'b1;
    a.want  = result_of(kind, slot, rpage, 1'b1);
    return a;
  endfunction

  task automatic move_to_front(input int unsigned slot, input int unsigned prv,
                               input bit prv_ok);
    if (slot != head_r) begin
      if (prv_ok) begin
        link_r[prv] = link_r[slot];
      end
      link_r[slot] = 6'(head_r);
      head_r = slot;
    end
  endtask

  // Walks the recency list for one access, updates the shadow state and leaves
  // the results the block must produce in lookup_results.
  task automatic cache_lookup(input logic [PageW-1:0] page, input logic wr,
                              input logic [SpW-1:0] sp);
    int unsigned cur;
    int unsigned prv;
    int unsigned sector;
    bit prv_ok;
    bit hit;
    bit at_tail;
    cur = head_r;
    prv = 0;
    prv_ok = 1'b0;
    hit = 1'b0;
    at_tail = 1'b0;
    lookup_results.delete();
    // The tag compare is plain, so the reserved all-ones page matches the
    // first empty slot on the way.
    for (int i = 0; i < Slots && !hit && !at_tail; i++) begin
      if (tag_r[cur] == page) begin
        hit = 1'b1;
      end else if (link_r[cur] >= Slots) begin
        at_tail = 1'b1;
      end else begin
        prv = cur;
        prv_ok = 1'b1;
        cur = link_r[cur];
      end
    end
    if (hit) begin
      if (wr) begin
        dirty_r[cur] = 1'b1;
      end
      move_to_front(cur, prv, prv_ok);
      lookup_results.push_back(result_of(KindHit, cur, page, 1'b1));
    end else if (!wr) begin
      lookup_results.push_back(result_of(KindBypass, 0, page, 1'b1));
    end else begin
      // A write miss takes the tail slot. A dirty victim at or above the stack
      // limit flushes every dirty slot of its sector, highest slot first.
      move_to_front(cur, prv, prv_ok);
      if (dirty_r[cur] && tag_r[cur] >= (sp >> SpShift)) begin
        sector = tag_r[cur] >> SectorShift;
        for (int s = Slots - 1; s >= 0; s--) begin
          if (dirty_r[s] && (tag_r[s] >> SectorShift) == sector) begin
            lookup_results.push_back(result_of(KindWriteBack, s, tag_r[s], 1'b0));
            dirty_r[s] = 1'b0;
          end
        end
      end
      tag_r[cur] = page;
      dirty_r[cur] = 1'b1;
      lookup_results.push_back(result_of(KindFill, cur, page, 1'b1));
    end
  endtask

  // Random accesses mostly hit a window of 64 pages, two sectors wide, so the
  // 32 slots keep missing, victims are usually dirty and whole sectors get
  // flushed. The rest are arbitrary pages and the reserved all-ones page.
  function automatic access_t random_access();
    access_t a;
    int unsigned pick;
    a = '0;
    pick = $urandom_range(99);
    if (pick < 78) begin
      a.page = pool_base + PageW'($urandom_range(63));
    end else if (pick < 93) begin
      a.page = PageW'($urandom);
    end else begin
      a.page = EmptyTag;
    end
    a.wr = ($urandom_range(99) < 70);
    // Small stack pointers let most victims flush; large ones, up to all
    // eleven bits set, hold the low pages back.
    pick = $urandom_range(99);
    if (pick < 50) begin
      a.sp = SpW'($urandom_range(127));
    end else if (pick < 80) begin
      a.sp = SpW'($urandom_range(1024));
    end else begin
      a.sp = SpW'($urandom_range(2047));
    end
    return a;
  endfunction

  // Access side. An item is predicted when the block takes it; a new item is
  // offered only when the line is free, so a stalled item never changes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cache_lookup(offered.page, offered.wr, offered.sp);
        if (offered.fixed) begin
          pending_results.push_back(offered.want);
        end else begin
          foreach (lookup_results[k]) begin
            pending_results.push_back(lookup_results[k]);
          end
        end
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = access_queue.pop_front();
          in_valid_i      <= 1'b1;
          page_address_i  <= offered.page;
          is_write_i      <= offered.wr;
          stack_pointer_i <= offered.sp;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input int unsigned expv,
                              input int unsigned actv);
    failures++;
    if (failures <= 60) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
    end
  endtask

  // Result side. Every result taken is compared with the oldest expectation.
  // The long hold-off is counted here, in cycles, once the main flow asks.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 60) begin
            $display("%0t: unexpected result, expected none, actual kind %0d slot %0d page %h",
                     $time, result_kind_o, slot_index_o, result_page_o);
          end
        end else begin
          want = pending_results.pop_front();
          kind_count[want.kind]++;
          if (result_kind_o !== want.kind) begin
            report_field("result_kind", want.kind, result_kind_o);
          end
          if (slot_index_o !== want.slot) begin
            report_field("slot_index", want.slot, slot_index_o);
          end
          if (result_page_o !== want.page) begin
            report_field("result_page", want.page, result_page_o);
          end
          if (last_o !== want.is_last) begin
            report_field("last", want.is_last, last_o);
          end
        end
      end
      if (hold_request) begin
        hold_left = LongHold;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("lru_page_cache_controller_core verification failed");
      $finish;
    end
  end

  // Waits until every queued item has been taken by the block.
  task automatic wait_accepted();
    while (access_queue.size() != 0 || in_valid_i) begin
      @(negedge clk_i);
    end
  endtask

  // Waits until every item is taken and every result has come back.
  task automatic wait_drained();
    wait_accepted();
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned send_pct,
                           input int unsigned recv_pct, input logic [PageW-1:0] base);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    pool_base     = base;
    repeat (n) begin
      access_queue.push_back(random_access());
    end
    wait_accepted();
  endtask

  initial begin
    // Reset state: slot i links to i + 1, all slots empty and clean.
    for (int i = 0; i < Slots; i++) begin
      link_r[i]  = (i + 1 < Slots) ? 6'(i + 1) : NoLink;
      dirty_r[i] = 1'b0;
      tag_r[i]   = EmptyTag;
    end
    head_r = 0;

    // Directed accesses. The first rows start from the reset state: reads
    // bypass, the all-ones page hits the first empty slot, and write misses
    // take the tail slots 31, 30, 29, 28 in turn. Later rows mix hits,
    // misses and the widest stack pointers and are left to the predictor.
    directed_table[0]  = fixed_row(16'h0000, 1'b0, 11'h000, KindBypass, 0,  16'h0000);
    directed_table[1]  = fixed_row(16'hfffe, 1'b0, 11'h7ff, KindBypass, 0,  16'hfffe);
    directed_table[2]  = fixed_row(16'hffff, 1'b0, 11'h000, KindHit,    0,  16'hffff);
    directed_table[3]  = fixed_row(16'h0000, 1'b1, 11'h000, KindFill,   31, 16'h0000);
    directed_table[4]  = fixed_row(16'h0001, 1'b1, 11'h000, KindFill,   30, 16'h0001);
    directed_table[5]  = fixed_row(16'h0000, 1'b1, 11'h000, KindHit,    31, 16'h0000);
    directed_table[6]  = fixed_row(16'h0001, 1'b0, 11'h000, KindHit,    30, 16'h0001);
    directed_table[7]  = fixed_row(16'hffff, 1'b1, 11'h000, KindHit,    0,  16'hffff);
    directed_table[8]  = fixed_row(16'h7fff, 1'b1, 11'h7ff, KindFill,   29, 16'h7fff);
    directed_table[9]  = fixed_row(16'h8000, 1'b1, 11'h400, KindFill,   28, 16'h8000);
    directed_table[10] = row(16'h0002, 1'b1, 11'h000);
    directed_table[11] = row(16'h001f, 1'b1, 11'h400);
    directed_table[12] = row(16'h0020, 1'b1, 11'h003);
    directed_table[13] = row(16'h5555, 1'b1, 11'h2aa);
    directed_table[14] = row(16'haaaa, 1'b1, 11'h555);
    directed_table[15] = row(16'h0002, 1'b0, 11'h000);
    directed_table[16] = row(16'h1234, 1'b0, 11'h400);
    directed_table[17] = row(16'h0000, 1'b1, 11'h7ff);
    directed_table[18] = row(16'hffff, 1'b0, 11'h000);
    directed_table[19] = row(16'h0003, 1'b1, 11'h000);
    directed_table[20] = row(16'h00ff, 1'b1, 11'h7ff);
    directed_table[21] = row(16'h00fe, 1'b0, 11'h7f8);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_table[i]) begin
      access_queue.push_back(directed_table[i]);
    end
    wait_drained();

    // Random part: first with no idling at all, then with a mostly idle
    // sender. Between phases the window of pages moves, so old dirty pages
    // turn into victims and their sectors get flushed.
    run_phase(44, 0, 0, 16'h0000);
    run_phase(44, 81, 0, PageW'($urandom_range(1023) << 6));

    // The sender pauses here until the block has returned every result.
    wait_drained();

    // The output side holds off for a long stretch while the sender keeps
    // offering, so the block fills up and stalls its input.
    @(negedge clk_i);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b1;
    repeat (16) begin
      access_queue.push_back(random_access());
    end
    wait_accepted();

    // The top window includes the reserved all-ones page.
    run_phase(44, 0, 81, 16'hffc0);
    run_phase(44, 15, 15, PageW'($urandom_range(1023) << 6));

    wait_drained();
    @(negedge clk_i);
    stall_pct = 0;
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d accesses in %0d cycles: %0d hits, %0d bypasses, %0d fills, %0d write-backs.",
             accepted_count, cycle_count, kind_count[KindHit], kind_count[KindBypass],
             kind_count[KindFill], kind_count[KindWriteBack]);
    $display("Phases covered free flow, idle sender, stalling receiver, a long hold-off and a drain.");
    if (failures == 0) begin
      $display("lru_page_cache_controller_core verification clean");
    end else begin
      $display("lru_page_cache_controller_core verification failed");
    end
    $finish;
  end

endmodule
